// ===== rtl/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants for the radio frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CS_LOW  = 3'd4,
        PH_CS_HIGH = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_OK       = 3'd1,
        EV_HDR_ONLY = 3'd2,
        EV_ACK      = 3'd3,
        EV_NACK     = 3'd4,
        EV_HDR_ERR  = 3'd5,
        EV_PAY_ERR  = 3'd6,
        EV_TOO_LONG = 3'd7
    } t_event;

    // Configuration register indexes.
    localparam logic [7:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [7:0] CFG_SYNC_SECOND = 8'd1;
    localparam logic [7:0] CFG_FULL_BIT    = 8'd2;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'd72;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd101;
    localparam logic [2:0] FULL_BIT_RST    = 3'd7;

    // Header status and size patterns of acknowledge frames.
    localparam logic [3:0] ACK_NIBBLE  = 4'h0a;
    localparam logic [7:0] ACK_SIZE    = 8'h0a;
    localparam logic [3:0] NACK_NIBBLE = 4'h0f;
    localparam logic [7:0] NACK_SIZE   = 8'hff;

    // Header: type, command, status, size.
    localparam int HDR_BYTES = 4;

endpackage

// ===== rtl/radio_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// radio_frame_deframer
// Sync hunt, header check and payload streaming for a radio link byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle with no gaps needed while
// results drain: each byte updates the frame phase and the Fletcher running
// sums, and any result is placed in the output register, which the next byte
// may enter behind as soon as it is empty or being drained in the same cycle.
// The result carries the event code, the payload byte for payload events, the
// command and size bytes of the current header, and the buffer-full and
// acknowledge flags last reported. Frames whose size exceeds MAX_PAYLOAD are
// flagged as too long and no payload is read. Configuration writes are always
// ready and take effect from the next byte.
module radio_frame_deframer #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_command_code,
    output logic [7:0] o_payload_length,
    output logic       o_radio_buffer_full,
    output logic       o_acknowledged,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [2:0] r_full_bit_pos;

    rfd_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_byte_count, n_byte_count;
    logic [7:0] r_header_bytes [rfd_pkg::HDR_BYTES];
    logic [7:0] n_header_bytes [rfd_pkg::HDR_BYTES];
    logic [7:0] r_sum_low, n_sum_low;
    logic [7:0] r_sum_high, n_sum_high;
    logic [15:0] r_header_sum, n_header_sum;
    logic [7:0] r_check_low, n_check_low;
    logic r_full_flag, n_full_flag;
    logic r_ack_flag, n_ack_flag;

    logic r_out_valid;
    rfd_pkg::t_event r_event;
    logic [7:0] r_data_byte;
    logic [7:0] r_command_code;
    logic [7:0] r_payload_length;
    logic r_buffer_full;
    logic r_acknowledged;

    logic in_accept;
    logic res_valid;
    rfd_pkg::t_event res_event;
    logic [7:0] res_data;
    logic [7:0] add_low;
    logic [7:0] add_high;
    logic [7:0] count_inc;
    logic [15:0] rx_check;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign add_low   = r_sum_low + i_rx_byte;
    assign add_high  = r_sum_high + add_low;
    assign count_inc = r_byte_count + 8'd1;
    assign rx_check  = {i_rx_byte, r_check_low};

    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_header_bytes = r_header_bytes;
        n_sum_low      = r_sum_low;
        n_sum_high     = r_sum_high;
        n_header_sum   = r_header_sum;
        n_check_low    = r_check_low;
        n_full_flag    = r_full_flag;
        n_ack_flag     = r_ack_flag;
        res_valid      = 1'b0;
        res_event      = rfd_pkg::EV_PAYLOAD;
        res_data       = 8'd0;
        case (r_phase)
            rfd_pkg::PH_SYNC2: begin
                if (i_rx_byte == r_sync_second) begin
                    n_phase      = rfd_pkg::PH_HEADER;
                    n_byte_count = 8'd0;
                    n_sum_low    = 8'd0;
                    n_sum_high   = 8'd0;
                end else begin
                    n_phase = rfd_pkg::PH_SYNC1;
                end
            end
            rfd_pkg::PH_HEADER: begin
                // The sums run over the check bytes too, as the payload
                // checksum covers the whole header.
                n_sum_low  = add_low;
                n_sum_high = add_high;
                if (r_byte_count < 8'd4) begin
                    n_header_bytes[r_byte_count[1:0]] = i_rx_byte;
                    if (r_byte_count == 8'd3) begin
                        n_header_sum = {add_high, add_low};
                    end
                    n_byte_count = count_inc;
                end else if (r_byte_count == 8'd4) begin
                    n_check_low  = i_rx_byte;
                    n_byte_count = 8'd5;
                end else begin
                    n_phase   = rfd_pkg::PH_SYNC1;
                    res_valid = 1'b1;
                    if (rx_check != r_header_sum) begin
                        res_event = rfd_pkg::EV_HDR_ERR;
                    end else if (r_header_bytes[2][3:0] == rfd_pkg::ACK_NIBBLE &&
                                 r_header_bytes[3] == rfd_pkg::ACK_SIZE) begin
                        n_full_flag = r_header_bytes[2][r_full_bit_pos];
                        n_ack_flag  = 1'b1;
                        res_event   = rfd_pkg::EV_ACK;
                    end else if (r_header_bytes[2][3:0] == rfd_pkg::NACK_NIBBLE &&
                                 r_header_bytes[3] == rfd_pkg::NACK_SIZE) begin
                        n_full_flag = r_header_bytes[2][r_full_bit_pos];
                        n_ack_flag  = 1'b0;
                        res_event   = rfd_pkg::EV_NACK;
                    end else if (r_header_bytes[3] == 8'd0) begin
                        res_event = rfd_pkg::EV_HDR_ONLY;
                    end else if (r_header_bytes[3] > MAX_LEN) begin
                        res_event = rfd_pkg::EV_TOO_LONG;
                    end else begin
                        res_valid    = 1'b0;
                        n_phase      = rfd_pkg::PH_PAYLOAD;
                        n_byte_count = 8'd0;
                    end
                end
            end
            rfd_pkg::PH_PAYLOAD: begin
                n_sum_low    = add_low;
                n_sum_high   = add_high;
                n_byte_count = count_inc;
                if (count_inc >= r_header_bytes[3]) begin
                    n_phase = rfd_pkg::PH_CS_LOW;
                end
                res_valid = 1'b1;
                res_event = rfd_pkg::EV_PAYLOAD;
                res_data  = i_rx_byte;
            end
            rfd_pkg::PH_CS_LOW: begin
                n_check_low = i_rx_byte;
                n_phase     = rfd_pkg::PH_CS_HIGH;
            end
            rfd_pkg::PH_CS_HIGH: begin
                n_phase   = rfd_pkg::PH_SYNC1;
                res_valid = 1'b1;
                res_event = (rx_check == {r_sum_high, r_sum_low}) ?
                            rfd_pkg::EV_OK : rfd_pkg::EV_PAY_ERR;
            end
            default: begin
                n_phase = (i_rx_byte == r_sync_first) ?
                          rfd_pkg::PH_SYNC2 : rfd_pkg::PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first   <= rfd_pkg::SYNC_FIRST_RST;
            r_sync_second  <= rfd_pkg::SYNC_SECOND_RST;
            r_full_bit_pos <= rfd_pkg::FULL_BIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rfd_pkg::CFG_SYNC_FIRST:  r_sync_first   <= i_cfg_data;
                rfd_pkg::CFG_SYNC_SECOND: r_sync_second  <= i_cfg_data;
                rfd_pkg::CFG_FULL_BIT:    r_full_bit_pos <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= rfd_pkg::PH_SYNC1;
            r_byte_count   <= 8'd0;
            r_header_bytes <= '{default: 8'd0};
            r_sum_low      <= 8'd0;
            r_sum_high     <= 8'd0;
            r_header_sum   <= 16'd0;
            r_check_low    <= 8'd0;
            r_full_flag    <= 1'b0;
            r_ack_flag     <= 1'b0;
        end else if (in_accept) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_header_bytes <= n_header_bytes;
            r_sum_low      <= n_sum_low;
            r_sum_high     <= n_sum_high;
            r_header_sum   <= n_header_sum;
            r_check_low    <= n_check_low;
            r_full_flag    <= n_full_flag;
            r_ack_flag     <= n_ack_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_event          <= res_event;
            r_data_byte      <= res_data;
            r_command_code   <= n_header_bytes[1];
            r_payload_length <= n_header_bytes[3];
            r_buffer_full    <= n_full_flag;
            r_acknowledged   <= n_ack_flag;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_event_res         = r_event;
    assign o_data_byte         = r_data_byte;
    assign o_command_code      = r_command_code;
    assign o_payload_length    = r_payload_length;
    assign o_radio_buffer_full = r_buffer_full;
    assign o_acknowledged      = r_acknowledged;

    // While streaming, the count never reaches the header size.
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == rfd_pkg::PH_PAYLOAD |-> r_byte_count < r_header_bytes[3])
        else $error("payload count reached header size while streaming");

    // The second checksum byte always closes the frame with a result.
    a_close_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_phase == rfd_pkg::PH_CS_HIGH |=> o_out_valid)
        else $error("no result after payload checksum");

    // Only payload events carry a data byte.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res != rfd_pkg::EV_PAYLOAD |-> o_data_byte == 8'd0)
        else $error("data byte set on a non-payload event");

    // A byte taken while streaming is always delivered as a payload result.
    a_payload_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_phase == rfd_pkg::PH_PAYLOAD |=>
            o_out_valid && o_event_res == rfd_pkg::EV_PAYLOAD)
        else $error("payload byte not delivered");

endmodule

// ===== bench/frame_event_checker.sv =====
// ----------------------------------------------------------------------------
// frame_event_checker
// Watches the byte, result and register channels of the radio frame deframer,
// works out the events each accepted byte should raise and compares every
// accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module frame_event_checker #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_event_res,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_command_code,
    input  logic [7:0] i_payload_length,
    input  logic       i_radio_buffer_full,
    input  logic       i_acknowledged,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] HDR_LAST    = 8'(rfd_pkg::HDR_BYTES - 1);
    localparam logic [7:0] HDR_CS_LOW  = 8'(rfd_pkg::HDR_BYTES);
    localparam logic [7:0] HDR_CS_HIGH = 8'(rfd_pkg::HDR_BYTES + 1);

    typedef struct packed {
        rfd_pkg::t_event ev;
        logic [7:0]      data;
        logic [7:0]      cmd;
        logic [7:0]      len;
        logic            full;
        logic            ack;
    } t_link_event;

    // Own copy of the deframer state and its registers.
    rfd_pkg::t_phase frame_phase;
    logic [7:0]  byte_idx;
    logic [7:0]  hdr [rfd_pkg::HDR_BYTES];
    logic [7:0]  sum_lo;
    logic [7:0]  sum_hi;
    logic [15:0] hdr_check;
    logic [7:0]  cs_lo;
    logic        buf_full;
    logic        acked;
    logic [7:0]  sync1;
    logic [7:0]  sync2;
    logic [2:0]  full_pos;

    t_link_event awaited_events[$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    function automatic void add_sum(input logic [7:0] b);
        sum_lo = sum_lo + b;
        sum_hi = sum_hi + sum_lo;
    endfunction

    function automatic void push_event(input rfd_pkg::t_event ev, input logic [7:0] d);
        t_link_event e;
        e.ev   = ev;
        e.data = d;
        e.cmd  = hdr[1];
        e.len  = hdr[3];
        e.full = buf_full;
        e.ack  = acked;
        awaited_events.push_back(e);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] rx_word;
        rx_word = {b, cs_lo};
        case (frame_phase)
            rfd_pkg::PH_SYNC2: begin
                if (b == sync2) begin
                    frame_phase = rfd_pkg::PH_HEADER;
                    byte_idx    = 8'd0;
                    sum_lo      = 8'd0;
                    sum_hi      = 8'd0;
                end else begin
                    frame_phase = rfd_pkg::PH_SYNC1;
                end
            end
            rfd_pkg::PH_HEADER: begin
                // The two header check bytes are summed as well, so the payload
                // check covers all six bytes after the sync.
                add_sum(b);
                if (byte_idx < HDR_CS_LOW) begin
                    hdr[byte_idx[1:0]] = b;
                    if (byte_idx == HDR_LAST) begin
                        hdr_check = {sum_hi, sum_lo};
                    end
                    byte_idx = byte_idx + 8'd1;
                end else if (byte_idx == HDR_CS_LOW) begin
                    cs_lo    = b;
                    byte_idx = HDR_CS_HIGH;
                end else begin
                    frame_phase = rfd_pkg::PH_SYNC1;
                    if (rx_word != hdr_check) begin
                        push_event(rfd_pkg::EV_HDR_ERR, 8'h00);
                    end else if (hdr[2][3:0] == rfd_pkg::ACK_NIBBLE &&
                                 hdr[3] == rfd_pkg::ACK_SIZE) begin
                        buf_full = hdr[2][full_pos];
                        acked    = 1'b1;
                        push_event(rfd_pkg::EV_ACK, 8'h00);
                    end else if (hdr[2][3:0] == rfd_pkg::NACK_NIBBLE &&
                                 hdr[3] == rfd_pkg::NACK_SIZE) begin
                        buf_full = hdr[2][full_pos];
                        acked    = 1'b0;
                        push_event(rfd_pkg::EV_NACK, 8'h00);
                    end else if (hdr[3] == 8'h00) begin
                        push_event(rfd_pkg::EV_HDR_ONLY, 8'h00);
                    end else if (int'(hdr[3]) > MAX_PAYLOAD) begin
                        push_event(rfd_pkg::EV_TOO_LONG, 8'h00);
                    end else begin
                        frame_phase = rfd_pkg::PH_PAYLOAD;
                        byte_idx    = 8'd0;
                    end
                end
            end
            rfd_pkg::PH_PAYLOAD: begin
                add_sum(b);
                byte_idx = byte_idx + 8'd1;
                if (byte_idx >= hdr[3]) begin
                    frame_phase = rfd_pkg::PH_CS_LOW;
                end
                push_event(rfd_pkg::EV_PAYLOAD, b);
            end
            rfd_pkg::PH_CS_LOW: begin
                cs_lo       = b;
                frame_phase = rfd_pkg::PH_CS_HIGH;
            end
            rfd_pkg::PH_CS_HIGH: begin
                frame_phase = rfd_pkg::PH_SYNC1;
                push_event((rx_word == {sum_hi, sum_lo}) ?
                           rfd_pkg::EV_OK : rfd_pkg::EV_PAY_ERR, 8'h00);
            end
            default: begin
                frame_phase = (b == sync1) ? rfd_pkg::PH_SYNC2 : rfd_pkg::PH_SYNC1;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_link_event want;
        logic        off;
        if (!i_rst_n) begin
            sync1       = rfd_pkg::SYNC_FIRST_RST;
            sync2       = rfd_pkg::SYNC_SECOND_RST;
            full_pos    = rfd_pkg::FULL_BIT_RST;
            frame_phase = rfd_pkg::PH_SYNC1;
            byte_idx    = 8'd0;
            for (int i = 0; i < rfd_pkg::HDR_BYTES; i++) begin
                hdr[i] = 8'd0;
            end
            sum_lo      = 8'd0;
            sum_hi      = 8'd0;
            hdr_check   = 16'd0;
            cs_lo       = 8'd0;
            buf_full    = 1'b0;
            acked       = 1'b0;
            awaited_events.delete();
        end else begin
            // A result can never come from the byte taken at the same edge, so
            // the comparison goes first.
            if (i_out_valid && i_out_ready) begin
                if (awaited_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, event %0d data %02h",
                                              i_event_res, i_data_byte));
                end else begin
                    want = awaited_events.pop_front();
                    off  = (i_event_res !== want.ev) || (i_data_byte !== want.data) ||
                           (i_command_code !== want.cmd) ||
                           (i_payload_length !== want.len) ||
                           (i_radio_buffer_full !== want.full) ||
                           (i_acknowledged !== want.ack);
                    if (off) begin
                        report_mismatch($sformatf(
                            {"got ev %0d data %02h cmd %02h len %02h full %b ack %b, ",
                             "want %s %02h %02h %02h %b %b"},
                            i_event_res, i_data_byte, i_command_code, i_payload_length,
                            i_radio_buffer_full, i_acknowledged, want.ev.name(),
                            want.data, want.cmd, want.len, want.full, want.ack));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_rx_byte);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rfd_pkg::CFG_SYNC_FIRST:  sync1    = i_cfg_data;
                    rfd_pkg::CFG_SYNC_SECOND: sync2    = i_cfg_data;
                    rfd_pkg::CFG_FULL_BIT:    full_pos = i_cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        o_pending = awaited_events.size();
    end

endmodule

// ===== bench/tb_radio_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_radio_frame_deframer
// Drives framed and corrupted radio link byte streams through the deframer
// under several sync and buffer-full settings, with random stalls on both
// channels, and reports the verdict of the event checker.
// ----------------------------------------------------------------------------
module tb_radio_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_PAYLOAD   = 255;
    localparam int         LIMIT_CYCLES  = 400000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         BIG_FRAMES    = 0;
    localparam int         SEGMENT_BYTES = 14;
    localparam logic [7:0] CFG_UNUSED_LO = 8'd3;
    localparam logic [7:0] CFG_UNUSED_HI = 8'hff;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic       radio_buffer_full;
    logic       acknowledged;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data  = 8'h00;

    int         fail_count;
    int         pending;
    int         cycles       = 0;
    int         bytes_sent   = 0;
    int         big_left     = BIG_FRAMES;
    int         rx_hold_seq  = 0;
    int         rx_hold_seen = 0;
    int         rx_hold_left = 0;
    int         rx_gap       = 0;
    bit         rx_bursty    = 1'b1;
    bit         calm         = 1'b0;
    bit         tx_gaps      = 1'b1;
    logic [7:0] sync_first_now  = rfd_pkg::SYNC_FIRST_RST;
    logic [7:0] sync_second_now = rfd_pkg::SYNC_SECOND_RST;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    radio_frame_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_rx_byte          (rx_byte),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_event_res        (event_res),
        .o_data_byte        (data_byte),
        .o_command_code     (command_code),
        .o_payload_length   (payload_length),
        .o_radio_buffer_full(radio_buffer_full),
        .o_acknowledged     (acknowledged),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    frame_event_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) event_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_rx_byte          (rx_byte),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_event_res        (event_res),
        .i_data_byte        (data_byte),
        .i_command_code     (command_code),
        .i_payload_length   (payload_length),
        .i_radio_buffer_full(radio_buffer_full),
        .i_acknowledged     (acknowledged),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request so
    // that the block fills up and has to refuse bytes.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            out_ready    <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_seen != rx_hold_seq) begin
            out_ready    <= 1'b0;
            rx_hold_left <= HOLD_CYCLES - 1;
            rx_hold_seen <= rx_hold_seq;
        end else if (rx_gap != 0) begin
            out_ready <= 1'b0;
            rx_gap    <= rx_gap - 1;
        end else if (!calm && rx_bursty && $urandom_range(0, 11) == 0) begin
            out_ready <= 1'b0;
            rx_gap    <= $urandom_range(0, 15);
        end else begin
            out_ready <= 1'b1;
        end
        if ($urandom_range(0, 199) == 0) begin
            rx_bursty <= ~rx_bursty;
        end
    end

    function automatic void fletcher_add(inout logic [7:0] lo, inout logic [7:0] hi,
                                         input logic [7:0] b);
        lo = lo + b;
        hi = hi + lo;
    endfunction

    // Returns at the edge where the byte was taken; valid stays high so that a
    // following byte can go straight out.
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && !calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            rfd_pkg::CFG_SYNC_FIRST:  sync_first_now  = data;
            rfd_pkg::CFG_SYNC_SECOND: sync_second_now = data;
            default: ;
        endcase
    endtask

    task automatic program_link(input logic [7:0] s1, input logic [7:0] s2,
                                input logic [7:0] fpos, input logic [7:0] bad_idx);
        wait_drained();
        cfg_write(rfd_pkg::CFG_SYNC_FIRST, s1);
        cfg_write(rfd_pkg::CFG_SYNC_SECOND, s2);
        cfg_write(rfd_pkg::CFG_FULL_BIT, fpos);
        cfg_write(bad_idx, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    // Builds one frame with correct checks unless told to spoil the header or
    // the payload check, and sends it.
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] cmd,
                              input logic [7:0] status, input logic [7:0] size,
                              input bit bad_hdr, input bit bad_pay);
        logic [7:0] fr[$];
        logic [7:0] hb[rfd_pkg::HDR_BYTES];
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] c_lo;
        logic [7:0] c_hi;
        logic [7:0] pb;
        logic [7:0] flip;
        bit         ack_like;
        hb = '{ftype, cmd, status, size};
        lo = 8'h00;
        hi = 8'h00;
        fr.push_back(sync_first_now);
        fr.push_back(sync_second_now);
        for (int i = 0; i < rfd_pkg::HDR_BYTES; i++) begin
            fr.push_back(hb[i]);
            fletcher_add(lo, hi, hb[i]);
        end
        c_lo = lo;
        c_hi = hi;
        flip = 8'h01 << $urandom_range(0, 7);
        if (bad_hdr) begin
            if ($urandom_range(0, 1) == 0) c_lo = c_lo ^ flip;
            else c_hi = c_hi ^ flip;
        end
        fr.push_back(c_lo);
        fletcher_add(lo, hi, c_lo);
        fr.push_back(c_hi);
        fletcher_add(lo, hi, c_hi);
        ack_like = (status[3:0] == rfd_pkg::ACK_NIBBLE && size == rfd_pkg::ACK_SIZE) ||
                   (status[3:0] == rfd_pkg::NACK_NIBBLE && size == rfd_pkg::NACK_SIZE);
        if (!bad_hdr && !ack_like && size != 8'h00) begin
            for (int i = 0; i < int'(size); i++) begin
                pb = 8'($urandom_range(0, 255));
                fr.push_back(pb);
                fletcher_add(lo, hi, pb);
            end
            c_lo = lo;
            c_hi = hi;
            if (bad_pay) begin
                if ($urandom_range(0, 1) == 0) c_lo = c_lo ^ flip;
                else c_hi = c_hi ^ flip;
            end
            fr.push_back(c_lo);
            fr.push_back(c_hi);
        end
        foreach (fr[i]) begin
            send_byte(fr[i]);
        end
    endtask

    // Mostly well-formed frames with random content, the rest corrupted frames,
    // stray bytes and broken sync sequences.
    task automatic random_traffic(input int nbytes);
        int         target;
        int         pick;
        logic [7:0] status;
        logic [7:0] size;
        target = bytes_sent + nbytes;
        while (bytes_sent < target) begin
            tx_gaps = ($urandom_range(0, 2) != 0);
            pick    = $urandom_range(0, 99);
            status  = 8'($urandom_range(0, 255));
            size    = 8'($urandom_range(1, 12));
            if (big_left > 0 && $urandom_range(0, 59) == 0) begin
                size = 8'hff;
                big_left--;
            end
            if (pick < 15) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           {4'($urandom_range(0, 15)), rfd_pkg::ACK_NIBBLE},
                           rfd_pkg::ACK_SIZE, 1'b0, 1'b0);
            end else if (pick < 28) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           {4'($urandom_range(0, 15)), rfd_pkg::NACK_NIBBLE},
                           rfd_pkg::NACK_SIZE, 1'b0, 1'b0);
            end else if (pick < 38) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           status, 8'h00, 1'b0, 1'b0);
            end else if (pick < 65) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           status, size, 1'b0, 1'b0);
            end else if (pick < 75) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           status, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end else if (pick < 85) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           status, size, 1'b0, 1'b1);
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                send_byte(sync_first_now);
                send_byte(sync_second_now ^ 8'($urandom_range(1, 255)));
            end else begin
                // Cut-off frame: the next frame's bytes are read as its header.
                send_byte(sync_first_now);
                send_byte(sync_second_now);
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [7:0] same_sync;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A wrong second sync equal to the first sync must not restart the
        // hunt; the following lone second sync is just a hunting byte.
        send_byte(sync_first_now);
        send_byte(sync_first_now);
        send_byte(sync_second_now);
        send_frame(8'h00, 8'hff, 8'h8a, rfd_pkg::ACK_SIZE, 1'b0, 1'b0);
        send_frame(8'hff, 8'h00, 8'h7f, rfd_pkg::NACK_SIZE, 1'b0, 1'b0);
        send_frame(8'h5a, 8'h3c, 8'h00, 8'h00, 1'b0, 1'b0);
        send_frame(8'h01, 8'h81, 8'hf0, 8'h01, 1'b0, 1'b0);
        // Acknowledge nibbles with other sizes carry a payload.
        send_frame(8'h22, 8'h44, 8'h0a, 8'h05, 1'b0, 1'b1);
        send_frame(8'h33, 8'h55, 8'hff, 8'h03, 1'b0, 1'b0);
        send_frame(8'h66, 8'h77, 8'h8a, rfd_pkg::ACK_SIZE, 1'b1, 1'b0);
        wait_drained();

        // Longest payload while the result side holds off.
        rx_hold_seq <= rx_hold_seq + 1;
        send_frame(8'h7e, 8'he7, 8'h00, 8'hff, 1'b0, 1'b0);
        wait_drained();

        random_traffic(SEGMENT_BYTES);
        program_link(8'h00, 8'hff, 8'h04, CFG_UNUSED_LO);
        random_traffic(SEGMENT_BYTES);
        // Upper data bits set; the buffer-full bit lands inside the status nibble.
        program_link(8'hff, 8'h00, 8'hf8, CFG_UNUSED_HI);
        random_traffic(SEGMENT_BYTES);
        program_link(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), CFG_UNUSED_LO);
        random_traffic(SEGMENT_BYTES);
        same_sync = 8'($urandom_range(0, 255));
        program_link(same_sync, same_sync, 8'h07, CFG_UNUSED_HI);
        calm <= 1'b1;
        random_traffic(SEGMENT_BYTES);
        wait_drained();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
